### src/css_pkg.sv
// Shared types, constants and helpers for the command stream splitter.
`default_nettype none
package css_pkg;

   localparam int unsigned CMD_W = 8;
   localparam int unsigned IDX_W = 16;
   localparam int unsigned CNT_W = 24;
   localparam int unsigned OFF_W = 32;
   localparam int unsigned BLK_W = 27;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 136;

   localparam logic [CMD_W-1:0] OPCODE_MASK = 8'hC0;
   localparam logic [CMD_W-1:0] JUMP_MASK = 8'h3F;
   localparam logic [5:0] JUMP_ESC2 = 6'd62;
   localparam logic [5:0] JUMP_ESC3 = 6'd63;
   localparam logic [1:0] OP_SET = 2'd1;

   // Block shift and data bytes per data command (as a shift) per layer mode.
   localparam int unsigned BLOCK_SHIFT_16L = 6;
   localparam int unsigned BLOCK_SHIFT_4L = 8;
   localparam int unsigned DATA_SHIFT_16L = 5;
   localparam int unsigned DATA_SHIFT_4L = 3;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;
   localparam logic [OFF_W-1:0] OFF_MAX = '1;

   localparam logic KIND_SPLIT = 1'b0;
   localparam logic KIND_FINAL = 1'b1;

   localparam logic [1:0] REG_NUM_ENTRY = 2'd0;
   localparam logic [1:0] REG_TOTAL = 2'd1;
   localparam logic [1:0] REG_LAYERS = 2'd2;

   typedef struct packed {
      logic [IDX_W-1:0] num_entry_points;
      logic [CNT_W-1:0] total_commands;
      logic             sixteen_layers;
   } cfg_type;

   typedef struct packed {
      logic             kind;
      logic [IDX_W-1:0] closed_index;
      logic [CNT_W-1:0] closed_count;
      logic [OFF_W-1:0] start_jump;
      logic [OFF_W-1:0] start_cmd_offset;
      logic [OFF_W-1:0] start_data_offset;
      logic             last;
   } rec_type;

   typedef struct packed {
      logic capture;
      logic clear;
      logic load_size;
      logic exec;
      logic sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       div_busy;
      logic [1:0] num_results;
   } dp_status_type;

   function automatic logic [OFF_W-1:0] sat_add32(input logic [OFF_W-1:0] a,
                                                  input logic [OFF_W-1:0] b);
      logic [OFF_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[OFF_W] ? OFF_MAX : s[OFF_W-1:0];
   endfunction

endpackage
`default_nettype wire

### src/css_div.sv
// Restoring divider, one quotient bit per cycle, for the group size.
`default_nettype none
module css_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [css_pkg::CNT_W-1:0] dividend,
   input  wire logic [css_pkg::IDX_W-1:0] divisor,
   output logic                           busy,
   output logic [css_pkg::CNT_W-1:0]      quotient
);
   import css_pkg::*;

   localparam int unsigned STEP_W = $clog2(CNT_W + 1);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  quo_ff, quo_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0]  dsr_ff, dsr_in;
   logic [IDX_W:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      trial = {rem_ff, quo_ff[CNT_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(CNT_W);
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = IDX_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[CNT_W-2:0], 1'b1};
         end else begin
            rem_in = trial[IDX_W-1:0];
            quo_in = {quo_ff[CNT_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy = busy_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

### src/css_datapath.sv
// Datapath: command decoding, position tracking, split decision and result records.
`default_nettype none
module css_datapath (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire css_pkg::cfg_type          cfg,
   input  wire logic [css_pkg::CMD_W-1:0] cmd_byte,
   input  wire css_pkg::ctrl_cmd_type     cmd,
   output css_pkg::dp_status_type         status,
   output css_pkg::rec_type               rec
);
   import css_pkg::*;

   logic [CMD_W-1:0] byte_ff, byte_in;
   logic [1:0]       phase_ff, phase_in;
   logic [2:0]       expected_ff, expected_in;
   logic [1:0]       opcode_ff, opcode_in;
   logic [CNT_W-1:0] jacc_ff, jacc_in;
   logic [OFF_W-1:0] cso_ff, cso_in;
   logic [OFF_W-1:0] tu_ff, tu_in;
   logic [OFF_W-1:0] boff_ff, boff_in;
   logic [CNT_W-1:0] dcnt_ff, dcnt_in;
   logic [CNT_W-1:0] cidx_ff, cidx_in;
   logic [IDX_W-1:0] gidx_ff, gidx_in;
   logic [CNT_W-1:0] gsize_ff, gsize_in;
   logic [OFF_W-1:0] thr_ff, thr_in;
   logic [BLK_W-1:0] pblk_ff, pblk_in;
   logic             pvalid_ff, pvalid_in;
   logic [CNT_W-1:0] gsc_ff, gsc_in;
   rec_type          rec0_ff, rec0_in, rec1_ff, rec1_in;
   logic [1:0]       nres_ff, nres_in;

   logic [CNT_W-1:0] quotient;
   logic             div_busy;

   logic [5:0]       sig;
   logic [CNT_W-1:0] jacc_new;
   logic [2:0]       phase_inc;
   logic             do_finish;
   logic [CNT_W-1:0] fin_jump;
   logic [1:0]       opcode_eff;
   logic [OFF_W-1:0] cso_eff;
   logic [OFF_W-1:0] tsum;
   logic [BLK_W-1:0] block;
   logic [IDX_W-1:0] entries_m1;
   logic             do_split, do_final, buf_done;
   logic [OFF_W-1:0] doff;
   logic [IDX_W-1:0] gidx_n;
   logic [CNT_W-1:0] gsc_n, cidx_n;
   rec_type          split_rec, final_rec;

   css_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.clear),
      .dividend (cfg.total_commands),
      .divisor  ((cfg.num_entry_points == '0) ? IDX_W'(1) : cfg.num_entry_points),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // Values of one completed command, computed whether or not one completes.
   always_comb begin
      sig = 6'(byte_ff & JUMP_MASK);
      jacc_new = jacc_ff;
      unique case (phase_ff)
         2'd1: jacc_new[7:0] = jacc_ff[7:0] | byte_ff;
         2'd2: jacc_new[15:8] = jacc_ff[15:8] | byte_ff;
         2'd3: jacc_new[23:16] = jacc_ff[23:16] | byte_ff;
         default: jacc_new = jacc_ff;
      endcase
      phase_inc = {1'b0, phase_ff} + 3'd1;
      if (phase_ff == 2'd0) begin
         do_finish = (sig != JUMP_ESC2) && (sig != JUMP_ESC3);
         fin_jump = CNT_W'(sig);
         opcode_eff = 2'((byte_ff & OPCODE_MASK) >> 6);
         cso_eff = boff_ff;
      end else begin
         do_finish = phase_inc > expected_ff;
         fin_jump = jacc_new;
         opcode_eff = opcode_ff;
         cso_eff = cso_ff;
      end

      tsum = sat_add32(tu_ff, OFF_W'(fin_jump));
      block = cfg.sixteen_layers ? BLK_W'(tsum >> BLOCK_SHIFT_16L)
                                 : BLK_W'(tsum >> BLOCK_SHIFT_4L);
      entries_m1 = (cfg.num_entry_points == '0) ? '0 : cfg.num_entry_points - IDX_W'(1);
      do_split = (OFF_W'(cidx_ff) > thr_ff) && (gidx_ff < entries_m1) &&
                 (!pvalid_ff || (block != pblk_ff));
      doff = cfg.sixteen_layers ? (OFF_W'(dcnt_ff) << DATA_SHIFT_16L)
                                : (OFF_W'(dcnt_ff) << DATA_SHIFT_4L);
      gidx_n = do_split ? gidx_ff + IDX_W'(1) : gidx_ff;
      gsc_n = do_split ? cidx_ff : gsc_ff;
      cidx_n = (cidx_ff == CNT_MAX) ? cidx_ff : cidx_ff + CNT_W'(1);
      do_final = cidx_n >= cfg.total_commands;
      buf_done = cidx_ff >= cfg.total_commands;

      split_rec.kind = KIND_SPLIT;
      split_rec.closed_index = gidx_ff;
      split_rec.closed_count = cidx_ff - gsc_ff;
      split_rec.start_jump = tu_ff;
      split_rec.start_cmd_offset = cso_eff;
      split_rec.start_data_offset = doff;
      split_rec.last = !do_final;

      final_rec.kind = KIND_FINAL;
      final_rec.closed_index = gidx_n;
      final_rec.closed_count = cidx_n - gsc_n;
      final_rec.start_jump = '0;
      final_rec.start_cmd_offset = '0;
      final_rec.start_data_offset = '0;
      final_rec.last = 1'b1;
   end

   always_comb begin
      byte_in = byte_ff;
      phase_in = phase_ff;
      expected_in = expected_ff;
      opcode_in = opcode_ff;
      jacc_in = jacc_ff;
      cso_in = cso_ff;
      tu_in = tu_ff;
      boff_in = boff_ff;
      dcnt_in = dcnt_ff;
      cidx_in = cidx_ff;
      gidx_in = gidx_ff;
      gsize_in = gsize_ff;
      thr_in = thr_ff;
      pblk_in = pblk_ff;
      pvalid_in = pvalid_ff;
      gsc_in = gsc_ff;
      rec0_in = rec0_ff;
      rec1_in = rec1_ff;
      nres_in = nres_ff;

      if (cmd.capture) begin
         byte_in = cmd_byte;
      end

      if (cmd.clear) begin
         phase_in = '0;
         expected_in = '0;
         opcode_in = '0;
         jacc_in = '0;
         cso_in = '0;
         tu_in = '0;
         boff_in = '0;
         dcnt_in = '0;
         cidx_in = '0;
         gidx_in = '0;
         gsize_in = '0;
         thr_in = '0;
         pblk_in = '0;
         pvalid_in = 1'b0;
         gsc_in = '0;
      end else if (cmd.load_size) begin
         gsize_in = quotient;
         thr_in = OFF_W'(quotient);
      end else if (cmd.exec) begin
         nres_in = '0;
         if (!buf_done) begin
            boff_in = sat_add32(boff_ff, OFF_W'(1));
            if (phase_ff == 2'd0) begin
               cso_in = boff_ff;
               opcode_in = opcode_eff;
               if (!do_finish) begin
                  expected_in = (sig == JUMP_ESC2) ? 3'd2 : 3'd3;
                  jacc_in = '0;
                  phase_in = 2'd1;
               end
            end else begin
               jacc_in = jacc_new;
               phase_in = do_finish ? 2'd0 : phase_inc[1:0];
            end
            if (do_finish) begin
               gidx_in = gidx_n;
               gsc_in = gsc_n;
               if (do_split) begin
                  thr_in = sat_add32(thr_ff, OFF_W'(gsize_ff));
               end
               pblk_in = block;
               pvalid_in = 1'b1;
               tu_in = tsum;
               if ((opcode_eff <= OP_SET) && (dcnt_ff != CNT_MAX)) begin
                  dcnt_in = dcnt_ff + CNT_W'(1);
               end
               cidx_in = cidx_n;
               if (do_split) begin
                  rec0_in = split_rec;
                  rec1_in = final_rec;
                  nres_in = do_final ? 2'd2 : 2'd1;
               end else if (do_final) begin
                  rec0_in = final_rec;
                  nres_in = 2'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         expected_ff <= '0;
         opcode_ff <= '0;
         jacc_ff <= '0;
         cso_ff <= '0;
         tu_ff <= '0;
         boff_ff <= '0;
         dcnt_ff <= '0;
         cidx_ff <= '0;
         gidx_ff <= '0;
         gsize_ff <= '0;
         thr_ff <= '0;
         pblk_ff <= '0;
         pvalid_ff <= 1'b0;
         gsc_ff <= '0;
         nres_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         expected_ff <= expected_in;
         opcode_ff <= opcode_in;
         jacc_ff <= jacc_in;
         cso_ff <= cso_in;
         tu_ff <= tu_in;
         boff_ff <= boff_in;
         dcnt_ff <= dcnt_in;
         cidx_ff <= cidx_in;
         gidx_ff <= gidx_in;
         gsize_ff <= gsize_in;
         thr_ff <= thr_in;
         pblk_ff <= pblk_in;
         pvalid_ff <= pvalid_in;
         gsc_ff <= gsc_in;
         nres_ff <= nres_in;
      end
      byte_ff <= byte_in;
      rec0_ff <= rec0_in;
      rec1_ff <= rec1_in;
   end

   assign status.div_busy = div_busy;
   assign status.num_results = nres_ff;
   assign rec = cmd.sel ? rec1_ff : rec0_ff;

endmodule
`default_nettype wire

### src/css_ctrl.sv
// Controller: sequences byte acceptance, group size division, processing and result beats.
`default_nettype none
module css_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_first,
   input  wire logic                  rsp_tready,
   input  wire css_pkg::dp_status_type status,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   output css_pkg::ctrl_cmd_type      cmd
);
   import css_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_EXEC, ST_SEND} state_type;

   state_type state_ff, state_in;
   logic      sel_ff, sel_in;
   logic      accept;

   always_comb begin
      accept = (state_ff == ST_IDLE) && req_tvalid;
      cmd.capture = accept;
      cmd.clear = accept && req_first;
      cmd.load_size = (state_ff == ST_DIVIDE) && !status.div_busy;
      cmd.exec = state_ff == ST_EXEC;
      cmd.sel = sel_ff;
      req_tready = state_ff == ST_IDLE;
      rsp_tvalid = (state_ff == ST_SEND) && (status.num_results != 2'd0);

      state_in = state_ff;
      sel_in = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            sel_in = 1'b0;
            if (accept) begin
               state_in = req_first ? ST_DIVIDE : ST_EXEC;
            end
         end
         ST_DIVIDE: begin
            if (!status.div_busy) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (status.num_results == 2'd0) begin
               state_in = ST_IDLE;
            end else if (rsp_tready) begin
               // The second beat only exists when the byte gave two records.
               if (sel_ff || (status.num_results == 2'd1)) begin
                  state_in = ST_IDLE;
                  sel_in = 1'b0;
               end else begin
                  sel_in = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff <= sel_in;
      end
   end

endmodule
`default_nettype wire

### src/command_stream_splitter_core.sv
// Top level of the command stream splitter: register port, controller and datapath.
//
//   Channel  Direction  Beat contents
//   req_     in         tdata: cmd_byte; tuser: first_byte
//   rsp_     out        tdata: closed_index..start_data_offset; tuser: record_kind;
//                       tlast: last
//   csr_     in/out     APB-style writes and reads of the three registers
//
// After acceptance a byte passes the execute state, then the send state, which gives
// one beat per record and holds while the result side stalls.
// A restarting byte first waits in the divide state for the bit-serial group size divider.
// Only one byte is in flight; req_tready is low until its records have all been taken.
// Reset is synchronous and returns all tracking and the registers to their reset values.
`default_nettype none
module command_stream_splitter_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [css_pkg::CMD_W-1:0]      req_tdata,  // [7:0] cmd_byte
   input  wire logic                           req_tuser,  // [0] first_byte
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [15:0] closed_index, [39:16] closed_count, [71:40] start_jump,
   // [103:72] start_cmd_offset, [135:104] start_data_offset
   output logic [css_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tuser,  // [0] record_kind
   output logic                                rsp_tlast,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [css_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [css_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [css_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import css_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   logic          csr_write;
   ctrl_cmd_type  cmd;
   dp_status_type status;
   rec_type       rec;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      csr_prdata = '0;
      case (csr_paddr[3:2])
         REG_NUM_ENTRY: begin
            csr_prdata = CSR_DATA_W'(cfg_ff.num_entry_points);
            if (csr_write) cfg_in.num_entry_points = csr_pwdata[IDX_W-1:0];
         end
         REG_TOTAL: begin
            csr_prdata = CSR_DATA_W'(cfg_ff.total_commands);
            if (csr_write) cfg_in.total_commands = csr_pwdata[CNT_W-1:0];
         end
         REG_LAYERS: begin
            csr_prdata = CSR_DATA_W'(cfg_ff.sixteen_layers);
            if (csr_write) cfg_in.sixteen_layers = csr_pwdata[0];
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_entry_points <= IDX_W'(1);
         cfg_ff.total_commands <= CNT_W'(1);
         cfg_ff.sixteen_layers <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   css_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_first  (req_tuser),
      .rsp_tready (rsp_tready),
      .status     (status),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   css_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .cmd_byte (req_tdata),
      .cmd      (cmd),
      .status   (status),
      .rec      (rec)
   );

   assign rsp_tdata = {rec.start_data_offset, rec.start_cmd_offset, rec.start_jump,
                       rec.closed_count, rec.closed_index};
   assign rsp_tuser = rec.kind;
   assign rsp_tlast = rec.last;

endmodule
`default_nettype wire

### src/css_checker.sv
// Port-level checks for the command stream splitter and their binding to the top level.
`default_nettype none
module css_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [css_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                           rsp_tuser,
   input wire logic                           rsp_tlast
);
   import css_pkg::*;

   // A stalled result beat keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // Only one byte is worked on at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted again right after a byte");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input ready while a result is pending");

   // A final record ends the byte's results and carries no start position.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_FINAL) |-> rsp_tlast && (rsp_tdata[135:40] == '0))
      else $error("malformed final record");

endmodule

bind command_stream_splitter_core css_checker u_css_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

### sim/command_stream_checker.sv
// Checker for the command stream splitter: watches all ports, predicts records, compares them.
module command_stream_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   input  wire logic [css_pkg::CMD_W-1:0]      req_tdata,  // [7:0] cmd_byte
   input  wire logic                           req_tuser,  // [0] first_byte
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [15:0] closed_index, [39:16] closed_count, [71:40] start_jump,
   // [103:72] start_cmd_offset, [135:104] start_data_offset
   input  wire logic [css_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                           rsp_tuser,  // [0] record_kind
   input  wire logic                           rsp_tlast,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [css_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [css_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic [css_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  wire logic                           csr_pready,
   output int                                  fail_count,
   output int                                  records_due
);
   import css_pkg::*;

   logic [IDX_W-1:0] cfg_entries;
   logic [CNT_W-1:0] cfg_total;
   logic             cfg_layers;

   logic [1:0]       phase_q;
   logic [2:0]       need_q;
   logic [1:0]       op_q;
   logic [CNT_W-1:0] acc_q;
   logic [OFF_W-1:0] cmd_start_q;
   logic [OFF_W-1:0] tu_q;
   logic [OFF_W-1:0] offset_q;
   logic [CNT_W-1:0] data_cnt_q;
   logic [CNT_W-1:0] cmd_cnt_q;
   logic [IDX_W-1:0] grp_q;
   logic [CNT_W-1:0] grp_size_q;
   logic [OFF_W-1:0] threshold_q;
   logic [OFF_W-1:0] prev_blk_q;
   logic             prev_blk_ok_q;
   logic [CNT_W-1:0] grp_start_q;

   rec_type due_records[$];

   initial fail_count = 0;

   function automatic logic [OFF_W-1:0] add_sat(input logic [OFF_W-1:0] a,
                                                input logic [OFF_W-1:0] b);
      logic [OFF_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[OFF_W] ? OFF_MAX : sum[OFF_W-1:0];
   endfunction

   task automatic clear_stream();
      phase_q = '0;
      need_q = '0;
      op_q = '0;
      acc_q = '0;
      cmd_start_q = '0;
      tu_q = '0;
      offset_q = '0;
      data_cnt_q = '0;
      cmd_cnt_q = '0;
      grp_q = '0;
      grp_size_q = '0;
      threshold_q = '0;
      prev_blk_q = '0;
      prev_blk_ok_q = 1'b0;
      grp_start_q = '0;
   endtask

   task automatic end_command(input logic [CNT_W-1:0] jump);
      logic [IDX_W-1:0] entries;
      logic [OFF_W-1:0] target;
      logic [OFF_W-1:0] blk;
      logic             split_now;
      logic             final_now;
      rec_type          split_rec;
      rec_type          final_rec;
      entries = (cfg_entries == '0) ? 16'd1 : cfg_entries;
      target = add_sat(tu_q, {8'd0, jump});
      blk = cfg_layers ? (target >> BLOCK_SHIFT_16L) : (target >> BLOCK_SHIFT_4L);
      // A split never falls between two commands that land in the same block.
      split_now = ({8'd0, cmd_cnt_q} > threshold_q) && (grp_q < entries - 16'd1) &&
                  (!prev_blk_ok_q || blk != prev_blk_q);
      split_rec = '0;
      if (split_now) begin
         split_rec.kind = KIND_SPLIT;
         split_rec.closed_index = grp_q;
         split_rec.closed_count = cmd_cnt_q - grp_start_q;
         split_rec.start_jump = tu_q;
         split_rec.start_cmd_offset = cmd_start_q;
         split_rec.start_data_offset = cfg_layers ? ({8'd0, data_cnt_q} << DATA_SHIFT_16L) :
                                                    ({8'd0, data_cnt_q} << DATA_SHIFT_4L);
         grp_q = grp_q + 16'd1;
         threshold_q = add_sat(threshold_q, {8'd0, grp_size_q});
         grp_start_q = cmd_cnt_q;
      end
      prev_blk_q = blk;
      prev_blk_ok_q = 1'b1;
      tu_q = target;
      if (op_q <= OP_SET && data_cnt_q != CNT_MAX)
         data_cnt_q = data_cnt_q + 24'd1;
      if (cmd_cnt_q != CNT_MAX)
         cmd_cnt_q = cmd_cnt_q + 24'd1;
      final_now = (cmd_cnt_q >= cfg_total);
      final_rec = '0;
      final_rec.kind = KIND_FINAL;
      final_rec.closed_index = grp_q;
      final_rec.closed_count = cmd_cnt_q - grp_start_q;
      final_rec.last = 1'b1;
      if (split_now) begin
         split_rec.last = !final_now;
         due_records.push_back(split_rec);
      end
      if (final_now)
         due_records.push_back(final_rec);
   endtask

   task automatic take_byte(input logic [CMD_W-1:0] b, input logic first);
      logic [IDX_W-1:0] entries;
      logic [5:0]       jump6;
      logic [2:0]       nxt;
      if (first) begin
         entries = (cfg_entries == '0) ? 16'd1 : cfg_entries;
         clear_stream();
         grp_size_q = 24'(cfg_total / {8'd0, entries});
         threshold_q = {8'd0, grp_size_q};
      end
      // Once the buffer is complete, bytes are dropped until the next restart.
      if (cmd_cnt_q < cfg_total) begin
         if (phase_q == 2'd0) begin
            cmd_start_q = offset_q;
            op_q = 2'((b & OPCODE_MASK) >> 6);
            jump6 = 6'(b & JUMP_MASK);
            if (jump6 < JUMP_ESC2) begin
               end_command({18'd0, jump6});
            end else begin
               need_q = (jump6 == JUMP_ESC2) ? 3'd2 : 3'd3;
               acc_q = '0;
               phase_q = 2'd1;
            end
         end else begin
            acc_q = acc_q | (24'(b) << (8 * (int'(phase_q) - 1)));
            nxt = {1'b0, phase_q} + 3'd1;
            if (nxt > need_q) begin
               phase_q = 2'd0;
               end_command(acc_q);
            end else begin
               phase_q = nxt[1:0];
            end
         end
         offset_q = add_sat(offset_q, 32'd1);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rec_type want;
      logic [31:0] reg_value;
      if (reset) begin
         cfg_entries = 16'd1;
         cfg_total = 24'd1;
         cfg_layers = 1'b0;
         clear_stream();
         due_records.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[3:2])
                  REG_NUM_ENTRY: cfg_entries = csr_pwdata[IDX_W-1:0];
                  REG_TOTAL:     cfg_total = csr_pwdata[CNT_W-1:0];
                  REG_LAYERS:    cfg_layers = csr_pwdata[0];
                  default: ;
               endcase
            end else begin
               case (csr_paddr[3:2])
                  REG_NUM_ENTRY: reg_value = {16'd0, cfg_entries};
                  REG_TOTAL:     reg_value = {8'd0, cfg_total};
                  default:       reg_value = {31'd0, cfg_layers};
               endcase
               check_field("prdata", reg_value, csr_prdata);
            end
         end
         if (req_tvalid && req_tready)
            take_byte(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (due_records.size() == 0) begin
               $error("record beat with no record due: kind %0d, tdata %0h",
                      rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = due_records.pop_front();
               check_field("record_kind", 32'(want.kind), 32'(rsp_tuser));
               check_field("closed_index", 32'(want.closed_index), 32'(rsp_tdata[15:0]));
               check_field("closed_count", 32'(want.closed_count), 32'(rsp_tdata[39:16]));
               check_field("start_jump", want.start_jump, rsp_tdata[71:40]);
               check_field("start_cmd_offset", want.start_cmd_offset, rsp_tdata[103:72]);
               check_field("start_data_offset", want.start_data_offset, rsp_tdata[135:104]);
               check_field("last", 32'(want.last), 32'(rsp_tlast));
            end
         end
      end
      records_due <= due_records.size();
   end

endmodule

### sim/testbench.sv
// Top of the splitter testbench: clock, reset, register setup, byte stimulus and verdict.
module testbench;
   import css_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_TAIL = 40;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [CMD_W-1:0]      req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    records_due;

   int send_idle_pct;
   int stall_pct;
   int stream_bytes;
   int cycles;

   int send_pct_tab[4] = '{0, 78, 0, 16};
   int stall_pct_tab[4] = '{0, 0, 78, 16};

   command_stream_splitter_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   command_stream_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .records_due (records_due)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Back-to-back accesses go straight from one access phase to the next setup phase.
   task automatic csr_access(input logic [1:0] idx, input logic write,
                             input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   task automatic set_registers(input logic [15:0] entries, input logic [23:0] total,
                                input logic layers);
      csr_access(REG_NUM_ENTRY, 1'b1, {16'd0, entries});
      csr_access(REG_TOTAL, 1'b1, {8'd0, total});
      csr_access(REG_LAYERS, 1'b1, {31'd0, layers});
      csr_access(REG_NUM_ENTRY, 1'b0, '0);
      csr_access(REG_TOTAL, 1'b0, '0);
      csr_access(REG_LAYERS, 1'b0, '0);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_byte(input logic [7:0] data, input logic first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Bytes that yield nothing may leave the block busy, hence the tail after the last record.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (records_due != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   task automatic send_command(input logic first);
      logic [1:0] op;
      logic [7:0] b1, b2, b3;
      int form;
      op = 2'($urandom_range(3));
      form = $urandom_range(99);
      b1 = 8'($urandom);
      b2 = 8'($urandom);
      b3 = 8'($urandom);
      if (form < 30) begin
         // Tiny jumps keep several commands in one block.
         send_byte({op, 6'($urandom_range(3))}, first);
         stream_bytes += 1;
      end else if (form < 60) begin
         send_byte({op, 6'($urandom_range(61))}, first);
         stream_bytes += 1;
      end else if (form < 80) begin
         send_byte({op, JUMP_ESC2}, first);
         send_byte(b1, 1'b0);
         send_byte(b2, 1'b0);
         stream_bytes += 3;
      end else begin
         if (form >= 95) begin
            b1 = 8'hFF;
            b2 = 8'hFF;
            b3 = 8'hFF;
         end
         send_byte({op, JUMP_ESC3}, first);
         send_byte(b1, 1'b0);
         send_byte(b2, 1'b0);
         send_byte(b3, 1'b0);
         stream_bytes += 4;
      end
   endtask

   task automatic run_buffer(input int ncmds);
      logic broken;
      int cut;
      broken = ($urandom_range(99) < 15);
      cut = $urandom_range(ncmds - 1);
      send_command(1'b1);
      for (int i = 1; i < ncmds; i++) begin
         if (broken && i == cut) begin
            // An escape cut short by a restart.
            send_byte({2'($urandom_range(3)), JUMP_ESC3}, 1'b0);
            send_byte(8'($urandom), 1'b0);
            stream_bytes += 2;
            send_command(1'b1);
         end else begin
            send_command(1'b0);
         end
      end
      repeat ($urandom_range(2)) send_byte(8'($urandom), 1'b0);
   endtask

   task automatic random_setting();
      logic [15:0] entries;
      logic [23:0] total;
      int pick;
      int ncmds;
      pick = $urandom_range(9);
      case (pick)
         0: entries = 16'd0;
         1: entries = 16'd1;
         2: entries = 16'hFFFF;
         default: entries = 16'($urandom_range(2, 8));
      endcase
      pick = $urandom_range(11);
      case (pick)
         0: total = 24'd1;
         1: total = 24'hFFFFFF;
         2: total = 24'd0;
         default: total = 24'($urandom_range(2, 48));
      endcase
      set_registers(entries, total, 1'($urandom_range(1)));
      if (total == 0) begin
         send_byte(8'($urandom), 1'b1);
         repeat (3) send_byte(8'($urandom), 1'b0);
      end else begin
         repeat ($urandom_range(1, 3)) begin
            if (total > 60)
               ncmds = $urandom_range(10, 40);
            else if ($urandom_range(9) == 0)
               ncmds = total + $urandom_range(1, 3);
            else
               ncmds = total;
            run_buffer(ncmds);
         end
      end
      drain();
   endtask

   initial begin
      int target;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      stream_bytes = 0;
      cycles = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Bytes before any restart run on the reset state; the second one is past the total.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      drain();

      set_registers(16'd3, 24'd7, 1'b1);
      send_byte(8'h05, 1'b1);
      send_byte(8'h7E, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hC0, 1'b0);
      send_byte(8'h3D, 1'b0);
      send_byte(8'h3F, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h41, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      drain();

      // Total lowered below the commands already seen: the next byte is dropped.
      set_registers(16'd3, 24'd2, 1'b1);
      send_byte(8'h00, 1'b0);
      drain();

      // Zero entry points behave as one.
      set_registers(16'd0, 24'd3, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      drain();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_pct_tab[p];
         stall_pct = stall_pct_tab[p];
         target = stream_bytes + 40;
         while (stream_bytes < target) random_setting();
      end

      drain();
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### files.f
src/css_pkg.sv
src/css_div.sv
src/css_datapath.sv
src/css_ctrl.sv
src/command_stream_splitter_core.sv
src/css_checker.sv
sim/command_stream_checker.sv
sim/testbench.sv
